FILE: rtl/binom_pkg.sv
// Shared types and constants for the binomial coefficient unit.
`default_nettype none

package binom_pkg;

    // Operand and result widths
    localparam int OPND_W = 6;
    localparam int COEF_W = 64;
    // Reduced k never exceeds 31, so the loop index and divisor fit 5 bits
    localparam int IDX_W  = 5;

    // Quotient bits retired per divide cycle, and divide steps per word
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = COEF_W / DIV_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/binomial_coefficient_unit.sv
// Binomial coefficient unit: n choose k by the multiplicative formula.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low;
//   n_total and k_choose are sampled on that edge. Exactly one result comes
//   back: coefficient is valid for the single cycle in which done is high,
//   and the receiver must take it then (there is no backpressure).
//   Trivial cases (n = 0, k > n, k = 0, k = n) return done in the cycle after
//   acceptance and busy stays low, so such transactions can be issued on
//   every cycle.
//   Otherwise k' = min(k, n-k) and the unit runs k' iterations, each one
//   multiply step (64 x 6 product, low 64 bits kept) followed by 8 divide
//   steps on a radix-256 long divider (one byte of quotient per cycle).
//   Busy is high while the iterations run and done follows in the first cycle
//   with busy low again, when the next transaction may already be accepted.
//   Asynchronous reset (rst_n low) returns the sequencer to idle and clears
//   done; an in-flight computation is dropped.
`default_nettype none

module binomial_coefficient_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [binom_pkg::OPND_W-1:0]        n_total,
    input  wire logic [binom_pkg::OPND_W-1:0]        k_choose,
    output logic                                     done,
    output logic      [binom_pkg::COEF_W-1:0]        coefficient
);

    binom_pkg::state_t                      state_reg, state_next;
    logic [binom_pkg::COEF_W-1:0]           acc_reg, acc_next;
    logic [binom_pkg::IDX_W-1:0]            rem_reg, rem_next;
    logic [binom_pkg::IDX_W-1:0]            i_reg, i_next;
    logic [binom_pkg::IDX_W-1:0]            kmin_reg, kmin_next;
    logic [binom_pkg::OPND_W-1:0]           base_reg, base_next;
    logic [binom_pkg::DCNT_W-1:0]           cnt_reg, cnt_next;
    logic                                   done_reg, done_next;

    // Setup terms for a new transaction
    logic [binom_pkg::OPND_W-1:0]           n_minus_k;
    logic [binom_pkg::OPND_W-1:0]           k_red;

    // Shared multiplier
    logic [binom_pkg::OPND_W-1:0]           factor;
    logic [binom_pkg::COEF_W+binom_pkg::OPND_W-1:0] prod;

    // Long divider slice
    logic [binom_pkg::DIV_BITS-1:0]         div_byte;
    logic [binom_pkg::DIV_BITS-1:0]         q_byte;
    logic [binom_pkg::IDX_W:0]              part_rem;

    assign busy        = (state_reg != binom_pkg::S_IDLE);
    assign done        = done_reg;
    assign coefficient = acc_reg;

    // min(k, n-k), valid when k <= n
    assign n_minus_k = n_total - k_choose;
    assign k_red     = (k_choose > n_minus_k) ? n_minus_k : k_choose;

    // Multiply by (n - k' + i), keep low 64 bits
    assign factor = base_reg + {1'b0, i_reg};
    assign prod   = {{binom_pkg::OPND_W{1'b0}}, acc_reg}
                  * {{binom_pkg::COEF_W{1'b0}}, factor};

    // One byte of restoring division by i; remainder stays below i
    always_comb
    begin
        div_byte = acc_reg[binom_pkg::COEF_W-1 -: binom_pkg::DIV_BITS];
        part_rem = {1'b0, rem_reg};
        q_byte   = '0;
        for (int j = binom_pkg::DIV_BITS - 1; j >= 0; j--)
        begin
            part_rem = {part_rem[binom_pkg::IDX_W-1:0], div_byte[j]};
            if (part_rem >= {1'b0, i_reg})
            begin
                part_rem  = part_rem - {1'b0, i_reg};
                q_byte[j] = 1'b1;
            end
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= binom_pkg::S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        kmin_reg <= kmin_next;
        base_reg <= base_next;
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        i_next     = i_reg;
        kmin_next  = kmin_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            binom_pkg::S_IDLE:
            begin
                if (start)
                begin
                    priority if (n_total == '0 || k_choose > n_total)
                    begin
                        acc_next  = '0;
                        done_next = 1'b1;
                    end
                    else if (k_choose == '0 || k_choose == n_total)
                    begin
                        acc_next  = {{(binom_pkg::COEF_W-1){1'b0}}, 1'b1};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        acc_next   = {{(binom_pkg::COEF_W-1){1'b0}}, 1'b1};
                        kmin_next  = k_red[binom_pkg::IDX_W-1:0];
                        base_next  = n_total - k_red;
                        i_next     = {{(binom_pkg::IDX_W-1){1'b0}}, 1'b1};
                        state_next = binom_pkg::S_MUL;
                    end
                end
            end

            binom_pkg::S_MUL:
            begin
                acc_next   = prod[binom_pkg::COEF_W-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = binom_pkg::S_DIV;
            end

            binom_pkg::S_DIV:
            begin
                acc_next = {acc_reg[binom_pkg::COEF_W-binom_pkg::DIV_BITS-1:0], q_byte};
                rem_next = part_rem[binom_pkg::IDX_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == binom_pkg::DCNT_W'(binom_pkg::DIV_STEPS - 1))
                begin
                    if (i_reg == kmin_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = binom_pkg::S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = binom_pkg::S_MUL;
                    end
                end
            end

            default:
            begin
                state_next = binom_pkg::S_IDLE;
            end
        endcase
    end

    // Result strobe only comes once the sequencer is back in idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // Divider remainder must stay below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == binom_pkg::S_DIV) |-> (rem_reg < i_reg))
        else $error("divider remainder out of range");

    // Loop index stays within 1..k' while computing
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (i_reg != '0 && i_reg <= kmin_reg))
        else $error("loop index out of range");

    // Zero upper operand returns zero on the next cycle
    a_zero_n: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && n_total == '0) |=> (done && coefficient == '0))
        else $error("n = 0 did not give zero");

endmodule

`default_nettype wire
